### hw/rtl/ycrc_pkg.sv
// ============================================================================
// ycrc_pkg
// Shared types, codes and the CRC helper function for the YMODEM CRC packet receiver.
// ============================================================================
package ycrc_pkg;

    localparam int SHORT_PAYLOAD = 128;
    localparam int LONG_PAYLOAD  = 1024;
    localparam int NAME_LIMIT    = 128;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] HDR_SOH = 8'h01;
    localparam logic [7:0] HDR_STX = 8'h02;
    localparam logic [7:0] HDR_EOT = 8'h04;
    localparam logic [7:0] HDR_CAN = 8'h18;

    localparam logic [1:0] KIND_NONE    = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_VERDICT = 2'd2;

    localparam logic [1:0] RSP_NONE = 2'd0;
    localparam logic [1:0] RSP_ACK  = 2'd1;
    localparam logic [1:0] RSP_NAK  = 2'd2;
    localparam logic [1:0] RSP_ACKC = 2'd3;

    localparam logic [3:0] OC_ACCEPTED   = 4'd0;
    localparam logic [3:0] OC_DUPLICATE  = 4'd1;
    localparam logic [3:0] OC_OUT_OF_SEQ = 4'd2;
    localparam logic [3:0] OC_CRC_ERROR  = 4'd3;
    localparam logic [3:0] OC_BAD_COMPL  = 4'd4;
    localparam logic [3:0] OC_BAD_HEADER = 4'd5;
    localparam logic [3:0] OC_TIMEOUT    = 4'd6;
    localparam logic [3:0] OC_FILE_START = 4'd7;
    localparam logic [3:0] OC_BATCH_END  = 4'd8;
    localparam logic [3:0] OC_BAD_BLOCK0 = 4'd9;
    localparam logic [3:0] OC_END_FILE   = 4'd10;
    localparam logic [3:0] OC_CANCELLED  = 4'd11;
    localparam logic [3:0] OC_IGNORED    = 4'd12;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [9:0]  payload_index;
        logic        keep;
        logic        is_block_zero;
        logic [3:0]  outcome;
        logic [1:0]  response;
        logic [7:0]  block_number;
        logic [31:0] size_reported;
    } t_out_word;

    // Frame position, one-hot.
    typedef enum logic [5:0] {
        FS_HEADER = 6'b000001,
        FS_BLOCK  = 6'b000010,
        FS_COMPL  = 6'b000100,
        FS_DATA   = 6'b001000,
        FS_CRC_HI = 6'b010000,
        FS_CRC_LO = 6'b100000
    } t_frame_step;

    // Classified work handed from the framer to the executor.
    typedef enum logic [2:0] {
        OP_DONE    = 3'd0,   // result fully formed by the framer
        OP_PAYLOAD = 3'd1,   // payload byte: needs keep and block 0 parse
        OP_CRC_END = 3'd2,   // last CRC byte: verdict from session state
        OP_EOT     = 3'd3,
        OP_CAN     = 3'd4,
        OP_HDRERR  = 3'd5,   // needs error response
        OP_TIMEOUT = 3'd6
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
        logic [9:0] offset;
        logic [7:0] block;
        logic       crc_ok;
        logic       long_block;
        logic       bad_compl;
    } t_task;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        end
        return c;
    endfunction

endpackage

### hw/rtl/ycrc_framer.sv
// ============================================================================
// ycrc_framer
// Front end: tracks packet framing, block number, complement and CRC.
// ============================================================================
module ycrc_framer
    import ycrc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_word i_word,
    input  logic     i_fire,
    output t_task    o_task
);

    t_frame_step r_step, n_step;
    logic        r_long, n_long;
    logic [7:0]  r_block, n_block;
    logic [9:0]  r_off, n_off;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_hi, n_crc_hi;
    logic        last_byte;

    assign last_byte = r_long ? (r_off == 10'(LONG_PAYLOAD - 1))
                              : (r_off == 10'(SHORT_PAYLOAD - 1));

    always_comb begin
        n_step   = r_step;
        n_long   = r_long;
        n_block  = r_block;
        n_off    = r_off;
        n_crc    = r_crc;
        n_crc_hi = r_crc_hi;
        o_task   = '0;
        o_task.op         = OP_DONE;
        o_task.rx_byte    = i_word.rx_byte;
        o_task.offset     = r_off;
        o_task.block      = r_block;
        o_task.long_block = r_long;
        o_task.crc_ok     = ({r_crc_hi, i_word.rx_byte} == r_crc);
        if (i_word.cmd) begin
            o_task.op = OP_TIMEOUT;
            n_step    = FS_HEADER;
        end else begin
            case (r_step)
                FS_HEADER: begin
                    if (i_word.rx_byte == HDR_SOH || i_word.rx_byte == HDR_STX) begin
                        n_long = (i_word.rx_byte == HDR_STX);
                        n_step = FS_BLOCK;
                    end else if (i_word.rx_byte == HDR_EOT) begin
                        o_task.op = OP_EOT;
                    end else if (i_word.rx_byte == HDR_CAN) begin
                        o_task.op = OP_CAN;
                        n_long    = 1'b0;
                        n_block   = '0;
                        n_off     = '0;
                        n_crc     = '0;
                        n_crc_hi  = '0;
                    end else begin
                        o_task.op = OP_HDRERR;
                    end
                end
                FS_BLOCK: begin
                    n_block = i_word.rx_byte;
                    n_step  = FS_COMPL;
                end
                FS_COMPL: begin
                    if (~r_block != i_word.rx_byte) begin
                        o_task.op        = OP_HDRERR;
                        o_task.bad_compl = 1'b1;
                        n_step           = FS_HEADER;
                    end else begin
                        n_step = FS_DATA;
                        n_off  = '0;
                        n_crc  = '0;
                    end
                end
                FS_DATA: begin
                    o_task.op = OP_PAYLOAD;
                    n_crc     = crc_update(r_crc, i_word.rx_byte);
                    if (last_byte) begin
                        n_step = FS_CRC_HI;
                        n_off  = '0;
                    end else begin
                        n_off = r_off + 10'd1;
                    end
                end
                FS_CRC_HI: begin
                    n_crc_hi = i_word.rx_byte;
                    n_step   = FS_CRC_LO;
                end
                FS_CRC_LO: begin
                    o_task.op = OP_CRC_END;
                    n_step    = FS_HEADER;
                end
                default: n_step = FS_HEADER;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= FS_HEADER;
            r_long   <= 1'b0;
            r_block  <= '0;
            r_off    <= '0;
            r_crc    <= '0;
            r_crc_hi <= '0;
        end else if (i_fire) begin
            r_step   <= n_step;
            r_long   <= n_long;
            r_block  <= n_block;
            r_off    <= n_off;
            r_crc    <= n_crc;
            r_crc_hi <= n_crc_hi;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_step)) else $error("frame step not one-hot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == FS_HEADER) |-> (r_off == '0 || $past(r_step) == FS_HEADER
            || $past(r_step) == FS_CRC_LO || $past(r_step) == FS_DATA
            || $past(r_step) == FS_COMPL || $past(r_step) == FS_BLOCK
            || $past(r_step) == FS_CRC_HI))
        else $error("offset bookkeeping broken");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_valid && r_step == FS_DATA && last_byte && !i_word.cmd)
        |=> (r_step == FS_CRC_HI && r_off == '0))
        else $error("payload end not followed by CRC");

endmodule

### hw/rtl/ycrc_queue.sv
// ============================================================================
// ycrc_queue
// Small FIFO between the framer and the session executor.
// ============================================================================
module ycrc_queue
    import ycrc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_task,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_empty,
    output t_task o_task
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_task           r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [AW:0]     r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_task  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_task;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            if (i_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop)) else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("queue underflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(DEPTH)) else $error("queue count out of range");

endmodule

### hw/rtl/ycrc_session.sv
// ============================================================================
// ycrc_session
// Back end: session state, block 0 parse, keep decision and verdicts.
// ============================================================================
module ycrc_session
    import ycrc_pkg::*;
#(
    parameter int NAME_MAX = NAME_LIMIT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_task     i_task,
    input  logic      i_go,
    output t_out_word o_word
);

    logic        r_data, n_data;
    logic [7:0]  r_expect, n_expect;
    logic [31:0] r_written, n_written;
    logic [31:0] r_flen, n_flen;
    logic [1:0]  r_meta, n_meta;
    logic [31:0] r_size, n_size;
    logic [1:0]  r_fault, n_fault;   // 0 none, 1 empty name, 2 bad

    logic        bz, digit;
    logic [1:0]  err_rsp;
    logic [31:0] rem, plen32, take;
    logic [35:0] mul10;
    logic [3:0]  dval;

    assign bz      = !r_data && (i_task.block == 8'd0);
    assign err_rsp = r_data ? RSP_NAK : RSP_NONE;
    assign digit   = (i_task.rx_byte >= 8'h30) && (i_task.rx_byte <= 8'h39);
    assign dval    = 4'(i_task.rx_byte - 8'h30);
    assign mul10   = {r_size, 3'b000} + {3'b000, r_size, 1'b0} + 36'(dval);
    assign rem     = (r_written < r_flen) ? (r_flen - r_written) : 32'd0;
    assign plen32  = i_task.long_block ? 32'(LONG_PAYLOAD) : 32'(SHORT_PAYLOAD);
    assign take    = (r_flen != 32'd0 && rem < plen32) ? rem : plen32;

    always_comb begin
        n_data    = r_data;
        n_expect  = r_expect;
        n_written = r_written;
        n_flen    = r_flen;
        n_meta    = r_meta;
        n_size    = r_size;
        n_fault   = r_fault;
        o_word    = '0;
        o_word.kind = KIND_VERDICT;
        case (i_task.op)
            OP_DONE: o_word.kind = KIND_NONE;
            OP_TIMEOUT: begin
                o_word.outcome  = OC_TIMEOUT;
                o_word.response = err_rsp;
            end
            OP_HDRERR: begin
                o_word.response = err_rsp;
                if (i_task.bad_compl) begin
                    o_word.outcome       = OC_BAD_COMPL;
                    o_word.is_block_zero = bz;
                    o_word.block_number  = i_task.block;
                    // The parse restarts only on a good complement.
                end else begin
                    o_word.outcome = OC_BAD_HEADER;
                end
            end
            OP_EOT: begin
                if (r_data) begin
                    n_data          = 1'b0;
                    o_word.outcome  = OC_END_FILE;
                    o_word.response = RSP_ACKC;
                end else begin
                    o_word.outcome = OC_IGNORED;
                end
            end
            OP_CAN: begin
                o_word.outcome = OC_CANCELLED;
                n_data    = 1'b0;
                n_expect  = 8'd1;
                n_written = '0;
                n_flen    = '0;
                n_meta    = '0;
                n_size    = '0;
                n_fault   = '0;
            end
            OP_PAYLOAD: begin
                o_word.kind          = KIND_PAYLOAD;
                o_word.data_byte     = i_task.rx_byte;
                o_word.payload_index = i_task.offset;
                o_word.is_block_zero = bz;
                o_word.block_number  = i_task.block;
                // A fresh packet restarts the block 0 parse.
                if (i_task.offset == '0) begin
                    n_meta  = '0;
                    n_size  = '0;
                    n_fault = '0;
                end
                if (bz) begin
                    if (i_task.offset == '0 || r_fault == 2'd0) begin
                        case ((i_task.offset == '0) ? 2'd0 : r_meta)
                            2'd0: begin
                                if (i_task.rx_byte == 8'd0) begin
                                    if (i_task.offset == '0) n_fault = 2'd1;
                                    else if (32'(i_task.offset) >= 32'(NAME_MAX))
                                        n_fault = 2'd2;
                                    else n_meta = 2'd1;
                                end
                            end
                            2'd1: begin
                                if (i_task.rx_byte == 8'd0) n_fault = 2'd2;
                                else if (digit) begin
                                    n_size = 32'(dval);
                                    n_meta = 2'd2;
                                end else n_meta = 2'd3;
                            end
                            2'd2: begin
                                if (digit) n_size = (mul10[35:32] != '0) ? 32'hFFFF_FFFF
                                                                          : mul10[31:0];
                                else n_meta = 2'd3;
                            end
                            default: ;
                        endcase
                    end
                end else if (r_data && i_task.block == r_expect) begin
                    o_word.keep = (r_flen == 32'd0) ||
                                  (r_written < r_flen && 32'(i_task.offset) < rem);
                end
            end
            OP_CRC_END: begin
                o_word.block_number = i_task.block;
                if (!i_task.crc_ok) begin
                    o_word.outcome       = OC_CRC_ERROR;
                    o_word.response      = err_rsp;
                    o_word.is_block_zero = bz;
                end else if (!r_data) begin
                    if (i_task.block != 8'd0) begin
                        o_word.outcome = OC_IGNORED;
                    end else begin
                        o_word.is_block_zero = 1'b1;
                        if (r_fault == 2'd1) begin
                            o_word.outcome  = OC_BATCH_END;
                            o_word.response = RSP_ACK;
                        end else if (r_fault == 2'd2 || r_meta < 2'd2) begin
                            o_word.outcome  = OC_BAD_BLOCK0;
                            o_word.response = RSP_NAK;
                        end else begin
                            o_word.outcome       = OC_FILE_START;
                            o_word.response      = RSP_ACKC;
                            o_word.size_reported = r_size;
                            n_flen    = r_size;
                            n_written = '0;
                            n_expect  = 8'd1;
                            n_data    = 1'b1;
                        end
                    end
                end else if (i_task.block == r_expect) begin
                    o_word.outcome  = OC_ACCEPTED;
                    o_word.response = RSP_ACK;
                    n_written = r_written + take;
                    n_expect  = r_expect + 8'd1;
                end else if (i_task.block == r_expect - 8'd1) begin
                    o_word.outcome  = OC_DUPLICATE;
                    o_word.response = RSP_ACK;
                end else begin
                    o_word.outcome  = OC_OUT_OF_SEQ;
                    o_word.response = RSP_NAK;
                end
            end
            default: o_word.kind = KIND_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data    <= 1'b0;
            r_expect  <= 8'd1;
            r_written <= '0;
            r_flen    <= '0;
            r_meta    <= '0;
            r_size    <= '0;
            r_fault   <= '0;
        end else if (i_go) begin
            r_data    <= n_data;
            r_expect  <= n_expect;
            r_written <= n_written;
            r_flen    <= n_flen;
            r_meta    <= n_meta;
            r_size    <= n_size;
            r_fault   <= n_fault;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault != 2'd3) else $error("illegal block 0 fault code");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_task.op == OP_CAN) |=> (!r_data && r_expect == 8'd1))
        else $error("cancel did not reset session");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && !r_data && i_task.op == OP_PAYLOAD) |-> !o_word.keep)
        else $error("byte kept outside data phase");

endmodule

### hw/rtl/ymodem_crc_packet_receiver.sv
// ============================================================================
// ymodem_crc_packet_receiver
// YMODEM CRC-16 receiver: framing front end, task queue, session back end.
// ============================================================================
// Each received byte or timeout tick is one input word and yields exactly one
// output word (kind 0 for bytes that produce nothing visible). A new word can
// be taken every clock cycle while the queue is not full: the front end checks
// the header, block number, complement and CRC-16/XMODEM as bytes arrive, and
// pushes a classified task into a two-entry queue. The back end pops one task
// per cycle unless the output side stalls, applies the session rules (block 0
// name and size parse, expected block, duplicates, file-size trimming) and
// loads the output register. Sustained throughput is one word per cycle when
// the output side is ready. An accepted task waits in the queue, and its
// result is loaded into the output register. The input stalls only when the
// queue is full, which happens when the output side stalls.
module ymodem_crc_packet_receiver
    import ycrc_pkg::*;
#(
    parameter int NAME_MAX = NAME_LIMIT,
    parameter int Q_DEPTH  = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_word  i_word,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_word o_word
);

    t_task     front_task, back_task;
    logic      q_full, q_empty, in_fire, pop;
    t_out_word result;
    logic      r_valid;
    t_out_word r_word;

    assign o_ready = !q_full;
    assign in_fire = i_valid && o_ready;

    // The back end runs when its output register is free or being emptied.
    assign pop = !q_empty && (!r_valid || i_ready);

    ycrc_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_word  (i_word),
        .i_fire  (in_fire),
        .o_task  (front_task)
    );

    ycrc_queue #(.DEPTH(Q_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_fire),
        .i_task  (front_task),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_task  (back_task)
    );

    ycrc_session #(.NAME_MAX(NAME_MAX)) u_session (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_task  (back_task),
        .i_go    (pop),
        .o_word  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) r_word <= result;
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_word)))
        else $error("output word changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> o_valid) else $error("popped task produced no output word");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !pop) else $error("output overwritten");

endmodule
